// ===== hw/rtl/hex_grid_face_enumerator_core_assert.svh =====
// Assertion macros for the hex grid face enumerator.
// No dependencies; included by the top level.
`ifndef HEX_GRID_FACE_ENUMERATOR_CORE_ASSERT_SVH
`define HEX_GRID_FACE_ENUMERATOR_CORE_ASSERT_SVH

`ifndef SYNTH
`define HGFE_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("hgfe assertion failed");
`define HGFE_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("hgfe assertion failed");
`else
`define HGFE_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define HGFE_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif

`endif

// ===== hw/rtl/hgfe_pkg.sv =====
// Package for the hex grid face enumerator: widths, codes, FSM and
// controller/datapath interface types. No dependencies.
`default_nettype none
package hgfe_pkg;

   localparam int DIM_W   = 10;
   localparam int IDX_W   = 30;
   localparam int NB_W    = 31;
   localparam int REQ_W   = 8;
   localparam int RSP_W   = 192;
   localparam int CSR_A_W = 2;

   localparam logic [DIM_W:0] MAX_CELLS_PER_AXIS = 11'd1023;

   localparam logic [1:0] DIR_X = 2'd0;
   localparam logic [1:0] DIR_Y = 2'd1;
   localparam logic [1:0] DIR_Z = 2'd2;

   localparam logic [CSR_A_W-1:0] CSR_CELLS_X = 2'd0;
   localparam logic [CSR_A_W-1:0] CSR_CELLS_Y = 2'd1;
   localparam logic [CSR_A_W-1:0] CSR_CELLS_Z = 2'd2;

   localparam logic [2:0] PATCH_INTERNAL = 3'd6;

   // rsp_tdata field positions
   localparam int RSP_DIR_LSB   = 0;
   localparam int RSP_A_LSB     = 2;
   localparam int RSP_B_LSB     = 32;
   localparam int RSP_C_LSB     = 62;
   localparam int RSP_D_LSB     = 92;
   localparam int RSP_OWN_LSB   = 122;
   localparam int RSP_NB_LSB    = 152;
   localparam int RSP_PATCH_LSB = 183;
   localparam int RSP_USED_W    = 186;

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_NORM = 5'b00010,
      ST_MUL1 = 5'b00100,
      ST_MUL2 = 5'b01000,
      ST_EMIT = 5'b10000
   } ctrl_state_type;

   typedef struct packed {
      logic accept;
      logic norm;
      logic mul1;
      logic mul2;
      logic load;
   } dp_cmd_type;

   typedef struct packed {
      logic out_free;
      logic out_valid;
   } dp_stat_type;

endpackage
`default_nettype wire

// ===== hw/rtl/hex_grid_face_enumerator_core.sv =====
// Each transfer on req_ yields the next face of a cells_x by cells_y by
// cells_z hexahedral grid on rsp_ (x-faces, then y-faces, then z-faces, k
// fastest), wrapping after the final z-face, which carries tlast. Each face
// goes through accept, position normalise, two index multiply steps and emit;
// emit waits while the result register still holds a face not yet taken. The
// result register lets the next request in while a face waits. The user must
// write sizes on the csr_ port while idle (not enforced); 0 counts as 1.
// Depends on hgfe_pkg, hgfe_ctrl, hgfe_datapath and the assertion header.
`default_nettype none
`include "hex_grid_face_enumerator_core_assert.svh"
module hex_grid_face_enumerator_core
   import hgfe_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_tvalid,
   output logic                    req_tready,
   input  wire logic [REQ_W-1:0]   req_tdata,   // [0] restart, rest zero
   output logic                    rsp_tvalid,
   input  wire logic               rsp_tready,
   output logic [RSP_W-1:0]        rsp_tdata,   // direction, corner_a..d, owner_cell,
                                                // neighbour_cell, patch_id, zero pad
   output logic                    rsp_tlast,   // last_face
   input  wire logic               csr_wr_en,
   input  wire logic [CSR_A_W-1:0] csr_index,
   input  wire logic [DIM_W-1:0]   csr_wdata
);

   dp_cmd_type  cmd;
   dp_stat_type stat;

   hgfe_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   hgfe_datapath u_dp (
      .clock      (clock),
      .reset      (reset),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .restart    (req_tdata[0]),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .cmd        (cmd),
      .stat       (stat)
   );

   assign rsp_tvalid = stat.out_valid;

   `HGFE_ASSERT_NXT(a_busy_after_accept, clock, reset, req_tvalid && req_tready, !req_tready)
   `HGFE_ASSERT_IMP(a_last_is_z, clock, reset, rsp_tvalid && rsp_tlast, rsp_tdata[RSP_DIR_LSB +: 2] == DIR_Z)
   `HGFE_ASSERT_IMP(a_inner_patch, clock, reset, rsp_tvalid && (rsp_tdata[RSP_NB_LSB +: NB_W] != '1), rsp_tdata[RSP_PATCH_LSB +: 3] == PATCH_INTERNAL)

endmodule
`default_nettype wire

// ===== hw/rtl/hgfe_ctrl.sv =====
// Sequencer for the hex grid face enumerator.
// Depends on hgfe_pkg.
`default_nettype none
module hgfe_ctrl
   import hgfe_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire dp_stat_type stat,
   output dp_cmd_type       cmd
);

   ctrl_state_type state_ff, state_in;

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.accept = 1'b1;
               state_in   = ST_NORM;
            end
         end
         ST_NORM: begin
            cmd.norm = 1'b1;
            state_in = ST_MUL1;
         end
         ST_MUL1: begin
            cmd.mul1 = 1'b1;
            state_in = ST_MUL2;
         end
         ST_MUL2: begin
            cmd.mul2 = 1'b1;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (stat.out_free) begin
               cmd.load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
`default_nettype wire

// ===== hw/rtl/hgfe_datapath.sv =====
// Datapath for the hex grid face enumerator: size registers, walk counters,
// index multipliers, corner/cell arithmetic and the result register.
// Depends on hgfe_pkg.
`default_nettype none
module hgfe_datapath
   import hgfe_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               csr_wr_en,
   input  wire logic [CSR_A_W-1:0] csr_index,
   input  wire logic [DIM_W-1:0]   csr_wdata,
   input  wire logic               restart,
   input  wire logic               rsp_tready,
   output logic [RSP_W-1:0]        rsp_tdata,
   output logic                    rsp_tlast,
   input  wire dp_cmd_type         cmd,
   output dp_stat_type             stat
);

   function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v);
      logic [DIM_W-1:0] r;
      r = v;
      if (v == '0) begin
         r = DIM_W'(1);
      end else if ({1'b0, v} > MAX_CELLS_PER_AXIS) begin
         r = MAX_CELLS_PER_AXIS[DIM_W-1:0];
      end
      return r;
   endfunction

   logic [DIM_W-1:0] cells_x_ff, cells_y_ff, cells_z_ff;
   logic [DIM_W-1:0] nx, ny, nz;
   logic [DIM_W:0]   ny1, nz1;

   logic [1:0]       axis_ff, axis_in;
   logic [DIM_W-1:0] ci_ff, cj_ff, ck_ff, ci_in, cj_in, ck_in;
   logic             restart_ff;

   logic [1:0]       ph_ff;
   logic [DIM_W-1:0] i_ff, j_ff, k_ff, mi_ff, mj_ff, mk_ff;
   logic             lower_ff, upper_ff, last_ff;

   logic [20:0]      ap_ff, syz_ff;
   logic [19:0]      ac_ff, yz_ff;
   logic [IDX_W-1:0] p_ff, c_ff, s1_ff, s3_ff, s13_ff, sc_ff;

   logic [RSP_W-1:0] rsp_data_ff, rsp_data_in;
   logic             rsp_last_ff, rsp_last_in;
   logic             rsp_valid_ff, rsp_valid_in;

   assign nx  = eff_dim(cells_x_ff);
   assign ny  = eff_dim(cells_y_ff);
   assign nz  = eff_dim(cells_z_ff);
   assign ny1 = {1'b0, ny} + 11'd1;
   assign nz1 = {1'b0, nz} + 11'd1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cells_x_ff <= DIM_W'(1);
         cells_y_ff <= DIM_W'(1);
         cells_z_ff <= DIM_W'(1);
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_CELLS_X: cells_x_ff <= csr_wdata;
            CSR_CELLS_Y: cells_y_ff <= csr_wdata;
            CSR_CELLS_Z: cells_z_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // normalise the walk position
   logic             bad, zap, out_rng;
   logic [1:0]       ph0, ph_n;
   logic [DIM_W-1:0] i0, j0, k0, mi0, mj0, mk0;
   logic [DIM_W-1:0] i_n, j_n, k_n, mi_n, mj_n, mk_n;
   logic             lower_n, upper_n, last_n;

   always_comb begin
      ph0 = restart_ff ? DIR_X : axis_ff;
      bad = (ph0 != DIR_X) && (ph0 != DIR_Y) && (ph0 != DIR_Z);
      zap = restart_ff || bad;
      if (bad) begin
         ph0 = DIR_X;
      end
      i0  = zap ? '0 : ci_ff;
      j0  = zap ? '0 : cj_ff;
      k0  = zap ? '0 : ck_ff;
      mi0 = (ph0 == DIR_X) ? nx : nx - DIM_W'(1);
      mj0 = (ph0 == DIR_Y) ? ny : ny - DIM_W'(1);
      mk0 = (ph0 == DIR_Z) ? nz : nz - DIM_W'(1);
      out_rng = (i0 > mi0) || (j0 > mj0) || (k0 > mk0);
      ph_n = out_rng ? DIR_X : ph0;
      i_n  = out_rng ? '0 : i0;
      j_n  = out_rng ? '0 : j0;
      k_n  = out_rng ? '0 : k0;
      mi_n = (ph_n == DIR_X) ? nx : nx - DIM_W'(1);
      mj_n = (ph_n == DIR_Y) ? ny : ny - DIM_W'(1);
      mk_n = (ph_n == DIR_Z) ? nz : nz - DIM_W'(1);
      case (ph_n)
         DIR_X: begin
            lower_n = (i_n == '0);
            upper_n = (i_n == nx);
         end
         DIR_Y: begin
            lower_n = (j_n == '0);
            upper_n = (j_n == ny);
         end
         default: begin
            lower_n = (k_n == '0);
            upper_n = (k_n == nz);
         end
      endcase
      last_n = (ph_n == DIR_Z) && (i_n == mi_n) && (j_n == mj_n) && (k_n == mk_n);
   end

   // advance the walk from the normalised position
   always_comb begin
      axis_in = axis_ff;
      ci_in   = ci_ff;
      cj_in   = cj_ff;
      ck_in   = ck_ff;
      if (cmd.mul1) begin
         axis_in = ph_ff;
         ci_in   = i_ff;
         cj_in   = j_ff;
         ck_in   = k_ff + DIM_W'(1);
         if (k_ff >= mk_ff) begin
            ck_in = '0;
            cj_in = j_ff + DIM_W'(1);
            if (j_ff >= mj_ff) begin
               cj_in = '0;
               ci_in = i_ff + DIM_W'(1);
               if (i_ff >= mi_ff) begin
                  ci_in   = '0;
                  axis_in = (ph_ff == DIR_Z) ? DIR_X : ph_ff + 2'd1;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         axis_ff <= DIR_X;
         ci_ff   <= '0;
         cj_ff   <= '0;
         ck_ff   <= '0;
      end else begin
         axis_ff <= axis_in;
         ci_ff   <= ci_in;
         cj_ff   <= cj_in;
         ck_ff   <= ck_in;
      end
   end

   // index arithmetic: two multiply steps
   logic [IDX_W-1:0] sz, syz30, yz30, p_mul, c_mul;
   assign sz    = IDX_W'(nz1);
   assign syz30 = IDX_W'(syz_ff);
   assign yz30  = IDX_W'(yz_ff);
   assign p_mul = IDX_W'(32'(ap_ff) * 32'(nz1) + 32'(k_ff));
   assign c_mul = IDX_W'(32'(ac_ff) * 32'(nz) + 32'(k_ff));

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         restart_ff <= restart;
      end
      if (cmd.norm) begin
         ph_ff    <= ph_n;
         i_ff     <= i_n;
         j_ff     <= j_n;
         k_ff     <= k_n;
         mi_ff    <= mi_n;
         mj_ff    <= mj_n;
         mk_ff    <= mk_n;
         lower_ff <= lower_n;
         upper_ff <= upper_n;
         last_ff  <= last_n;
      end
      if (cmd.mul1) begin
         ap_ff  <= 21'(21'(i_ff) * 21'(ny1) + 21'(j_ff));
         ac_ff  <= 20'(20'(i_ff) * 20'(ny) + 20'(j_ff));
         syz_ff <= 21'(21'(ny1) * 21'(nz1));
         yz_ff  <= 20'(20'(ny) * 20'(nz));
      end
      if (cmd.mul2) begin
         p_ff <= p_mul;
         c_ff <= c_mul;
         case (ph_ff)
            DIR_X: begin
               s1_ff  <= sz;
               s3_ff  <= IDX_W'(1);
               s13_ff <= sz + IDX_W'(1);
               sc_ff  <= yz30;
            end
            DIR_Y: begin
               s1_ff  <= IDX_W'(1);
               s3_ff  <= syz30;
               s13_ff <= syz30 + IDX_W'(1);
               sc_ff  <= IDX_W'(nz);
            end
            default: begin
               s1_ff  <= syz30;
               s3_ff  <= sz;
               s13_ff <= syz30 + sz;
               sc_ff  <= IDX_W'(1);
            end
         endcase
      end
   end

   // face assembly
   logic [IDX_W-1:0] c1, c2, c3, own;
   logic [NB_W-1:0]  nb;
   logic [2:0]       pid;

   always_comb begin
      c1  = p_ff + s1_ff;
      c2  = p_ff + s13_ff;
      c3  = p_ff + s3_ff;
      own = lower_ff ? c_ff : c_ff - sc_ff;
      nb  = (lower_ff || upper_ff) ? '1 : {1'b0, c_ff};
      if (lower_ff) begin
         pid = {ph_ff, 1'b0};
      end else if (upper_ff) begin
         pid = {ph_ff, 1'b1};
      end else begin
         pid = PATCH_INTERNAL;
      end
      if (lower_ff) begin
         rsp_data_in = {{(RSP_W-RSP_USED_W){1'b0}}, pid, nb, own, p_ff, c1, c2, c3, ph_ff};
      end else begin
         rsp_data_in = {{(RSP_W-RSP_USED_W){1'b0}}, pid, nb, own, c3, c2, c1, p_ff, ph_ff};
      end
      rsp_last_in = last_ff;
   end

   assign rsp_valid_in = cmd.load || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (cmd.load) begin
         rsp_data_ff <= rsp_data_in;
         rsp_last_ff <= rsp_last_in;
      end
   end

   assign rsp_tdata      = rsp_data_ff;
   assign rsp_tlast      = rsp_last_ff;
   assign stat.out_free  = !rsp_valid_ff || rsp_tready;
   assign stat.out_valid = rsp_valid_ff;

endmodule
`default_nettype wire
